// ----- rtl/pcf_pkg.sv -----
package pcf_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  localparam logic [63:0] PNG_SIG   = 64'h89504E470D0A1A0A;
  localparam logic [31:0] TYPE_IHDR = 32'h49484452;
  localparam logic [31:0] TYPE_IDAT = 32'h49444154;
  localparam logic [31:0] TYPE_IEND = 32'h49454E44;
  localparam logic [31:0] IHDR_LEN  = 32'd13;
  localparam logic [7:0]  BIT_DEPTH  = 8'd8;
  localparam logic [7:0]  COLOR_TYPE = 8'd2;

  localparam int REG_W = 31;

  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_IDAT_LENGTH  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       file_done;
    logic       length_mismatch;
  } result_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] word_byte(logic [31:0] w, logic [5:0] rel);
    logic [7:0] r;
    case (rel)
      6'd0:    r = w[31:24];
      6'd1:    r = w[23:16];
      6'd2:    r = w[15:8];
      default: r = w[7:0];
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/png_container_framer_core.sv -----
// channel | direction | handshake                  | beat
// item    | in        | item_valid / item_stall    | item_t: data_byte, is_last
// res     | out       | res_valid / res_stall      | result_t: out_byte, flags
// cfg     | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One output byte per cycle from the result register, unless res stalls. A plain
// data item gives its data byte only, the first item of a file also the header
// burst, the last the trailer burst, an item that opens and closes a file both.
// The CRC-32 unit takes the chunk type and data bytes, one per cycle unless res stalls, in line with the output byte.
// rst is synchronous: clears the control state, sets the configuration registers to 1.
// A stall on res holds the result register and, through it, the item stage.
module png_container_framer_core
  import pcf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  item_t              item,
  output logic               res_valid,
  input  logic               res_stall,
  output result_t            res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [REG_W-1:0]   cfg_data
);

  localparam logic [5:0] P_SIG    = 6'd0;
  localparam logic [5:0] P_ILEN   = 6'd8;
  localparam logic [5:0] P_ITYPE  = 6'd12;
  localparam logic [5:0] P_WIDTH  = 6'd16;
  localparam logic [5:0] P_HEIGHT = 6'd20;
  localparam logic [5:0] P_DEPTH  = 6'd24;
  localparam logic [5:0] P_CTYPE  = 6'd25;
  localparam logic [5:0] P_METH   = 6'd26;
  localparam logic [5:0] P_ICRC   = 6'd29;
  localparam logic [5:0] P_DLEN   = 6'd33;
  localparam logic [5:0] P_DTYPE  = 6'd37;
  localparam logic [5:0] P_DATA   = 6'd41;
  localparam logic [5:0] P_DCRC   = 6'd42;
  localparam logic [5:0] P_ZLEN   = 6'd46;
  localparam logic [5:0] P_ETYPE  = 6'd50;
  localparam logic [5:0] P_ECRC   = 6'd54;
  localparam logic [5:0] P_END    = 6'd57;

  logic [REG_W-1:0] image_width;
  logic [REG_W-1:0] image_height;
  logic [REG_W-1:0] idat_length;

  item_t       item_q;
  logic        item_full;
  logic [5:0]  pos;
  logic [31:0] crc;
  logic [31:0] byte_count;

  logic        emit;
  logic        final_beat;
  logic [7:0]  cur_byte;
  logic [31:0] crc_upd;
  logic [5:0]  pos_next;
  logic        mismatch;

  assign cfg_ready  = 1'b1;
  assign emit       = item_full && (!res_valid || !res_stall);
  assign final_beat = (pos == P_END) || ((pos == P_DATA) && !item_q.is_last);
  assign item_stall = item_full && !(emit && final_beat);
  assign crc_upd    = crc_byte(crc, cur_byte);
  assign mismatch   = byte_count != {1'b0, idat_length};

  always_comb begin
    case (pos) inside
      [P_SIG:P_ILEN-6'd1]:      cur_byte = PNG_SIG[{3'd7 - pos[2:0], 3'd0} +: 8];
      [P_ILEN:P_ITYPE-6'd1]:    cur_byte = word_byte(IHDR_LEN, pos - P_ILEN);
      [P_ITYPE:P_WIDTH-6'd1]:   cur_byte = word_byte(TYPE_IHDR, pos - P_ITYPE);
      [P_WIDTH:P_HEIGHT-6'd1]:  cur_byte = word_byte({1'b0, image_width}, pos - P_WIDTH);
      [P_HEIGHT:P_DEPTH-6'd1]:  cur_byte = word_byte({1'b0, image_height}, pos - P_HEIGHT);
      P_DEPTH:                  cur_byte = BIT_DEPTH;
      P_CTYPE:                  cur_byte = COLOR_TYPE;
      [P_METH:P_ICRC-6'd1]:     cur_byte = 8'd0;
      [P_ICRC:P_DLEN-6'd1]:     cur_byte = word_byte(crc ^ CRC_ONES, pos - P_ICRC);
      [P_DLEN:P_DTYPE-6'd1]:    cur_byte = word_byte({1'b0, idat_length}, pos - P_DLEN);
      [P_DTYPE:P_DATA-6'd1]:    cur_byte = word_byte(TYPE_IDAT, pos - P_DTYPE);
      P_DATA:                   cur_byte = item_q.data_byte;
      [P_DCRC:P_ZLEN-6'd1]:     cur_byte = word_byte(crc ^ CRC_ONES, pos - P_DCRC);
      [P_ZLEN:P_ETYPE-6'd1]:    cur_byte = 8'd0;
      [P_ETYPE:P_ECRC-6'd1]:    cur_byte = word_byte(TYPE_IEND, pos - P_ETYPE);
      [P_ECRC:P_END]:           cur_byte = word_byte(crc ^ CRC_ONES, pos - P_ECRC);
      default:                  cur_byte = 8'd0;
    endcase
  end

  always_comb begin
    if (pos == P_END) begin
      pos_next = P_SIG;
    end else if (pos == P_DATA) begin
      pos_next = item_q.is_last ? P_DCRC : P_DATA;
    end else begin
      pos_next = pos + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= REG_W'(1);
      image_height <= REG_W'(1);
      idat_length  <= REG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        CFG_IDAT_LENGTH:  idat_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q <= item;
    end
    if (emit) begin
      res.out_byte        <= cur_byte;
      res.run_last        <= final_beat;
      res.file_done       <= pos == P_END;
      res.length_mismatch <= (pos == P_END) && mismatch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full  <= 1'b0;
      res_valid  <= 1'b0;
      pos        <= P_SIG;
      crc        <= CRC_ONES;
      byte_count <= 32'd0;
    end else begin
      if (item_valid && !item_stall) begin
        item_full <= 1'b1;
      end else if (emit && final_beat) begin
        item_full <= 1'b0;
      end

      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end

      if (emit) begin
        pos <= pos_next;
        case (pos) inside
          [P_ITYPE:P_ICRC-6'd1], [P_DTYPE:P_DATA], [P_ETYPE:P_ECRC-6'd1]:
            crc <= crc_upd;
          P_DLEN-6'd1, P_ZLEN-6'd1, P_END:
            crc <= CRC_ONES;
          default: ;
        endcase
        if (pos == P_DATA) begin
          byte_count <= (byte_count == CRC_ONES) ? byte_count : byte_count + 32'd1;
        end else if (pos == P_END) begin
          byte_count <= 32'd0;
        end
      end
    end
  end

endmodule

// ----- rtl/pcf_checker.sv -----
module pcf_checker
  import pcf_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_stall,
  input result_t            res
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  a_done_closes_run: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.file_done |-> res.run_last)
    else $error("file end not on the last beat of an item");

  a_mismatch_at_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.length_mismatch |-> res.file_done)
    else $error("length flag away from file end");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind png_container_framer_core pcf_checker u_pcf_checker (.*);
